// File: design/dpgs_pkg.sv
package dpgs_pkg;

    localparam int LEVEL_W    = 8;
    localparam int POS_W      = 12;
    localparam int DIM_W      = 13;
    localparam int TGT_W      = 16;
    localparam int CNT_W      = 25;
    localparam int STRIDE_W   = 13;
    localparam int SQ_W       = 2 * STRIDE_W;
    localparam int PROD_W     = SQ_W + TGT_W;
    localparam int FRAC_W     = 16;
    localparam int BIT_W      = 4;
    localparam int STEP_W     = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_PARTICLES = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DARK_THRESHOLD   = 2'd3;

    localparam logic [DIM_W-1:0]    WIDTH_RESET     = 13'd640;
    localparam logic [DIM_W-1:0]    HEIGHT_RESET    = 13'd480;
    localparam logic [TGT_W-1:0]    TARGET_RESET    = 16'd1000;
    localparam logic [LEVEL_W-1:0]  THRESHOLD_RESET = 8'd50;

    localparam logic [CNT_W-1:0]    DARK_MAX     = '1;
    localparam logic [BIT_W-1:0]    ROOT_TOP_BIT = 4'd12;
    localparam logic [STEP_W-1:0]   DIV_LAST     = 4'd15;
    localparam logic [FRAC_W-1:0]   FRAC_SAT     = '1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROOT_SQ,
        ST_ROOT_CMP,
        ST_DIV,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic accept;
        logic root_start;
        logic root_sq;
        logic root_cmp;
        logic div_step;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic stride_go;
        logic hit;
        logic root_done;
        logic div_done;
        logic out_free;
        logic mod_ok;
    } status_t;

endpackage

// File: design/dark_pixel_grid_sampler_top.sv
// an item with no result is accepted while idle; a sampled pixel runs the 16-step divider for
// both coordinates, then the output register raises m_tvalid once it is free
// throughput: 1 item per cycle while idle; s_tready is low during the divider, the output wait
// and the 13-bit root search (square then multiply-compare per bit) after a counting pass ends
// reset: synchronous active-low aresetn; registers to 640/480/1000/50, position and count
// cleared, stride 1, output empty
module dark_pixel_grid_sampler_top #(
    parameter int MAX_DIM = 4096
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [dpgs_pkg::CFG_IDX_W-1:0]     cfg_addr,
    input  logic [dpgs_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [7:0]                         s_tdata,   // pixel_level
    input  logic                               s_tuser,   // pass_select
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [31:0]                        m_tdata    // x_fraction, y_fraction
);
    import dpgs_pkg::*;

    cmd_t              cmd;
    status_t           st;
    logic [FRAC_W-1:0] x_fraction, y_fraction;

    dpgs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    dpgs_datapath #(
        .MAX_DIM (MAX_DIM)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata),
        .pass_select (s_tuser),
        .pixel_level (s_tdata),
        .cmd         (cmd),
        .st          (st),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .x_fraction  (x_fraction),
        .y_fraction  (y_fraction)
    );

    assign m_tdata = {y_fraction, x_fraction};

    // residues stay below a nonzero stride
    a_mod_ok: assert property (@(posedge aclk) disable iff (!aresetn) st.mod_ok)
        else $error("stride residue out of range");

    // a result only replaces a beat that is gone
    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_tvalid || m_tready))
        else $error("result overwrote a pending beat");

    a_valid_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(cmd.out_load))
        else $error("output valid without a load");

endmodule

// File: design/dpgs_ctrl.sv
module dpgs_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  dpgs_pkg::status_t st,
    output dpgs_pkg::cmd_t    cmd
);
    import dpgs_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.accept = 1'b1;
                    if (st.stride_go) begin
                        cmd.root_start = 1'b1;
                        state_next     = ST_ROOT_SQ;
                    end else if (st.hit) begin
                        state_next = ST_DIV;
                    end
                end
            end
            ST_ROOT_SQ: begin
                cmd.root_sq = 1'b1;
                state_next  = ST_ROOT_CMP;
            end
            ST_ROOT_CMP: begin
                cmd.root_cmp = 1'b1;
                state_next   = st.root_done ? ST_IDLE : ST_ROOT_SQ;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (st.div_done) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (st.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

// File: design/dpgs_datapath.sv
module dpgs_datapath #(
    parameter int MAX_DIM = 4096
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [dpgs_pkg::CFG_IDX_W-1:0]      cfg_addr,
    input  logic [dpgs_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic                                pass_select,
    input  logic [dpgs_pkg::LEVEL_W-1:0]        pixel_level,
    input  dpgs_pkg::cmd_t                      cmd,
    output dpgs_pkg::status_t                   st,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [dpgs_pkg::FRAC_W-1:0]         x_fraction,
    output logic [dpgs_pkg::FRAC_W-1:0]         y_fraction
);
    import dpgs_pkg::*;

    logic [DIM_W-1:0]    w_reg, h_reg;
    logic [TGT_W-1:0]    tgt_reg;
    logic [LEVEL_W-1:0]  thr_reg;
    logic [POS_W-1:0]    col_reg, row_reg, col_next, row_next;
    logic [STRIDE_W-1:0] cm_reg, rm_reg, cm_next, rm_next;
    logic [CNT_W-1:0]    dark_reg, dark_next, dark_base;
    logic [STRIDE_W-1:0] stride_reg, root_reg, root_next, cand;
    logic [BIT_W-1:0]    bit_reg;
    logic [SQ_W-1:0]     sq_reg;
    logic [PROD_W-1:0]   prod;
    logic [DIM_W-1:0]    remx_reg, remy_reg, remx_next, remy_next;
    logic [DIM_W:0]      rsx, rsy;
    logic                gex, gey;
    logic [FRAC_W-1:0]   qx_reg, qy_reg, outx_reg, outy_reg;
    logic                satx_reg, saty_reg, out_valid_reg;
    logic [STEP_W-1:0]   step_reg;
    logic [DIM_W-1:0]    w_eff, h_eff;
    logic [TGT_W-1:0]    tgt_eff;
    logic                dark, row_end, last, restart;
    logic [DIM_W-1:0]    row_inc, col_inc;

    // zero acts as one, above the limit acts as the limit
    always_comb begin
        if (w_reg == '0) w_eff = DIM_W'(1);
        else if (32'(w_reg) > MAX_DIM) w_eff = DIM_W'(MAX_DIM);
        else w_eff = w_reg;
        if (h_reg == '0) h_eff = DIM_W'(1);
        else if (32'(h_reg) > MAX_DIM) h_eff = DIM_W'(MAX_DIM);
        else h_eff = h_reg;
        tgt_eff = (tgt_reg == '0) ? TGT_W'(1) : tgt_reg;
    end

    assign dark    = pixel_level <= thr_reg;
    assign row_inc = {1'b0, row_reg} + DIM_W'(1);
    assign col_inc = {1'b0, col_reg} + DIM_W'(1);
    assign row_end = row_inc >= h_eff;
    assign last    = row_end && (col_inc >= w_eff);
    assign restart = (col_reg == '0) && (row_reg == '0);

    // position and its residues modulo the stride
    always_comb begin
        row_next = row_reg;
        col_next = col_reg;
        rm_next  = rm_reg;
        cm_next  = cm_reg;
        if (row_end) begin
            row_next = '0;
            rm_next  = '0;
            if (last) begin
                col_next = '0;
                cm_next  = '0;
            end else begin
                col_next = col_inc[POS_W-1:0];
                if (col_next == '0 || cm_reg + STRIDE_W'(1) == stride_reg) cm_next = '0;
                else cm_next = cm_reg + STRIDE_W'(1);
            end
        end else begin
            row_next = row_inc[POS_W-1:0];
            if (row_next == '0 || rm_reg + STRIDE_W'(1) == stride_reg) rm_next = '0;
            else rm_next = rm_reg + STRIDE_W'(1);
        end
    end

    always_comb begin
        dark_base = restart ? '0 : dark_reg;
        dark_next = (dark && dark_base != DARK_MAX) ? dark_base + CNT_W'(1) : dark_base;
    end

    assign cand = root_reg | (STRIDE_W'(1) << bit_reg);
    assign prod = PROD_W'(sq_reg) * PROD_W'(tgt_eff);
    assign root_next = (prod <= PROD_W'(dark_reg)) ? cand : root_reg;

    // one quotient bit per step for each coordinate
    always_comb begin
        rsx       = {remx_reg, 1'b0};
        rsy       = {remy_reg, 1'b0};
        gex       = rsx >= {1'b0, w_eff};
        gey       = rsy >= {1'b0, h_eff};
        remx_next = gex ? DIM_W'(rsx - {1'b0, w_eff}) : rsx[DIM_W-1:0];
        remy_next = gey ? DIM_W'(rsy - {1'b0, h_eff}) : rsy[DIM_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            w_reg         <= WIDTH_RESET;
            h_reg         <= HEIGHT_RESET;
            tgt_reg       <= TARGET_RESET;
            thr_reg       <= THRESHOLD_RESET;
            col_reg       <= '0;
            row_reg       <= '0;
            cm_reg        <= '0;
            rm_reg        <= '0;
            dark_reg      <= '0;
            stride_reg    <= STRIDE_W'(1);
            root_reg      <= '0;
            bit_reg       <= '0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_addr)
                    REG_IMAGE_WIDTH:      w_reg   <= cfg_wdata[DIM_W-1:0];
                    REG_IMAGE_HEIGHT:     h_reg   <= cfg_wdata[DIM_W-1:0];
                    REG_TARGET_PARTICLES: tgt_reg <= cfg_wdata[TGT_W-1:0];
                    REG_DARK_THRESHOLD:   thr_reg <= cfg_wdata[LEVEL_W-1:0];
                    default: ;
                endcase
            end
            if (cmd.accept) begin
                col_reg <= col_next;
                row_reg <= row_next;
                cm_reg  <= cm_next;
                rm_reg  <= rm_next;
                if (!pass_select) begin
                    dark_reg <= dark_next;
                end
                if (st.hit) begin
                    step_reg <= '0;
                end
            end
            if (cmd.root_start) begin
                root_reg <= '0;
                bit_reg  <= ROOT_TOP_BIT;
            end
            if (cmd.root_cmp) begin
                root_reg <= root_next;
                if (bit_reg == '0) begin
                    stride_reg <= (root_next == '0) ? STRIDE_W'(1) : root_next;
                end else begin
                    bit_reg <= bit_reg - BIT_W'(1);
                end
            end
            if (cmd.div_step) begin
                step_reg <= step_reg + STEP_W'(1);
            end
            if (cmd.out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept && st.hit) begin
            remx_reg <= {1'b0, col_reg};
            remy_reg <= {1'b0, row_reg};
            satx_reg <= {1'b0, col_reg} >= w_eff;
            saty_reg <= {1'b0, row_reg} >= h_eff;
            qx_reg   <= '0;
            qy_reg   <= '0;
        end
        if (cmd.root_sq) begin
            sq_reg <= SQ_W'(cand) * SQ_W'(cand);
        end
        if (cmd.div_step) begin
            remx_reg <= remx_next;
            remy_reg <= remy_next;
            qx_reg   <= {qx_reg[FRAC_W-2:0], gex};
            qy_reg   <= {qy_reg[FRAC_W-2:0], gey};
        end
        if (cmd.out_load) begin
            outx_reg <= satx_reg ? FRAC_SAT : qx_reg;
            outy_reg <= saty_reg ? FRAC_SAT : qy_reg;
        end
    end

    always_comb begin
        st           = '0;
        st.stride_go = !pass_select && last;
        st.hit       = pass_select && dark && (cm_reg == '0) && (rm_reg == '0);
        st.root_done = bit_reg == '0;
        st.div_done  = step_reg == DIV_LAST;
        st.out_free  = !out_valid_reg || m_tready;
        st.mod_ok    = (stride_reg != '0) && (cm_reg < stride_reg) && (rm_reg < stride_reg);
    end

    assign m_tvalid   = out_valid_reg;
    assign x_fraction = outx_reg;
    assign y_fraction = outy_reg;

endmodule
